### hw/rtl/wildcard_substring_search_core_assert.svh
// Assertion macros shared by the wildcard substring search RTL.
`ifndef WILDCARD_SUBSTRING_SEARCH_CORE_ASSERT_SVH
`define WILDCARD_SUBSTRING_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define WSS_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication under the active-low reset.
`define WSS_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### hw/rtl/wss_pkg.sv
// Package with the types, constants and matching function of the substring search.
`timescale 1ns / 1ps

package wss_pkg;

    localparam int MAX_PATTERN_DEF  = 16;
    localparam int MAX_SENTENCE_DEF = 4096;

    localparam int CHAR_W     = 8;
    localparam int POS_W      = 13;
    localparam int LEN_W      = 5;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [CHAR_W-1:0] CH_DIGIT_CLASS  = 8'h3C; // '<'
    localparam logic [CHAR_W-1:0] CH_LETTER_CLASS = 8'h3E; // '>'
    localparam logic [CHAR_W-1:0] CH_ANY_CLASS    = 8'h5F; // '_'
    localparam logic [CHAR_W-1:0] CH_SPACE        = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO         = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE         = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOWER_A      = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z      = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UPPER_A      = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z      = 8'h5A;

    typedef enum logic [1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2,
        REG_SPECIAL_MODE   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic step;
        logic clear;
        logic special;
    } cell_ctl_t;

    function automatic logic char_matches(input logic [CHAR_W-1:0] p,
                                          input logic [CHAR_W-1:0] c,
                                          input logic special);
        logic is_digit;
        logic is_letter;
        logic result;
        is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_letter = ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
                    ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
        if (special && (p == CH_DIGIT_CLASS))
        begin
            result = is_digit;
        end
        else if (special && (p == CH_LETTER_CLASS))
        begin
            result = is_letter;
        end
        else if (special && (p == CH_ANY_CLASS))
        begin
            result = (c != CH_SPACE);
        end
        else
        begin
            result = (p == c);
        end
        return result;
    endfunction

endpackage

### hw/rtl/wss_cell.sv
// One pattern position of the shift-and chain: compares the text and holds a partial match bit.
`timescale 1ns / 1ps

module wss_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wss_pkg::cell_ctl_t           ctl,
    input  logic [wss_pkg::CHAR_W-1:0]   text_char,
    input  logic [wss_pkg::CHAR_W-1:0]   pattern_char,
    input  logic                         active,
    input  logic                         tail,
    input  logic                         prev_match,
    output logic                         match,
    output logic                         hit
);

    logic match_reg;
    logic match_next;
    logic step_bit;

    assign step_bit = prev_match && active &&
                      wss_pkg::char_matches(pattern_char, text_char, ctl.special);
    assign hit      = step_bit && tail;

    always_comb
    begin
        match_next = match_reg;
        if (ctl.clear)
        begin
            match_next = 1'b0;
        end
        else if (ctl.step)
        begin
            match_next = step_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

### hw/rtl/wildcard_substring_search_core.sv
// Wildcard substring search: shift-and cell chain, configuration registers and result buffer.
// Throughput: one text word per cycle, sustained, as long as results are taken.
// A result word is registered in the output register, or in the skid register while an earlier result waits.
// The shift-and update is a recurrence through the cell chain, held in each cell's match register.
// A two-word result buffer lets text keep flowing while one result waits.
// Reset clears the match state and buffer; pattern 0, length 1, literal mode.
`timescale 1ns / 1ps

`include "wildcard_substring_search_core_assert.svh"

module wildcard_substring_search_core #(
    parameter int MAX_PATTERN  = wss_pkg::MAX_PATTERN_DEF,
    parameter int MAX_SENTENCE = wss_pkg::MAX_SENTENCE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wss_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [wss_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [wss_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              text_valid,
    output logic                              text_ready,
    input  logic [wss_pkg::CHAR_W-1:0]        text_char,
    input  logic                              end_of_sentence,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic                              found,
    output logic [wss_pkg::POS_W-1:0]         start_position,
    output logic                              last
);

    localparam int CNT_W = $clog2(MAX_SENTENCE + 1);
    localparam int SUB_W = (CNT_W > wss_pkg::POS_W) ? CNT_W : wss_pkg::POS_W;

    typedef struct packed {
        logic                       found;
        logic [wss_pkg::POS_W-1:0]  pos;
    } result_t;

    // Configuration registers.
    logic [63:0]                pattern_low_reg;
    logic [63:0]                pattern_high_reg;
    logic [wss_pkg::LEN_W-1:0]  pattern_length_reg;
    logic                       special_mode_reg;
    wss_pkg::cfg_index_t        cfg_index;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = wss_pkg::cfg_index_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= wss_pkg::LEN_W'(1);
            special_mode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wss_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                wss_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                wss_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[wss_pkg::LEN_W-1:0];
                wss_pkg::REG_SPECIAL_MODE:   special_mode_reg   <= pwdata[0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            wss_pkg::REG_PATTERN_LOW:    prdata = pattern_low_reg;
            wss_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            wss_pkg::REG_PATTERN_LENGTH: prdata = wss_pkg::CFG_DATA_W'(pattern_length_reg);
            wss_pkg::REG_SPECIAL_MODE:   prdata = wss_pkg::CFG_DATA_W'(special_mode_reg);
            default:                     prdata = '0;
        endcase
    end

    // Sentence state.
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           count_inc;
    logic                       reported_reg;
    logic                       reported_next;
    logic [wss_pkg::LEN_W-1:0]  len_eff;
    logic                       in_accept;
    logic                       step;
    logic                       any_hit;
    logic                       push;
    result_t                    new_result;
    wss_pkg::cell_ctl_t         cell_ctl;
    logic [MAX_PATTERN-1:0]     match_vec;
    logic [MAX_PATTERN-1:0]     hit_vec;
    logic [SUB_W-1:0]           start_full;

    assign in_accept = text_valid && text_ready;
    assign step      = in_accept && !reported_reg;

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_eff = wss_pkg::LEN_W'(1);
        end
        else if (pattern_length_reg > wss_pkg::LEN_W'(MAX_PATTERN))
        begin
            len_eff = wss_pkg::LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = pattern_length_reg;
        end
    end

    assign count_inc = (count_reg < CNT_W'(MAX_SENTENCE)) ? count_reg + CNT_W'(1) : count_reg;

    assign cell_ctl.step    = step;
    assign cell_ctl.clear   = in_accept && end_of_sentence;
    assign cell_ctl.special = special_mode_reg;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic [wss_pkg::CHAR_W-1:0] pchar;
            logic                       prev;

            if (k < 8)
            begin : g_low
                assign pchar = pattern_low_reg[8*k +: 8];
            end
            else
            begin : g_high
                assign pchar = pattern_high_reg[8*(k-8) +: 8];
            end

            if (k == 0)
            begin : g_head
                assign prev = 1'b1;
            end
            else
            begin : g_link
                assign prev = match_vec[k-1];
            end

            wss_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (cell_ctl),
                .text_char    (text_char),
                .pattern_char (pchar),
                .active       (wss_pkg::LEN_W'(k) < len_eff),
                .tail         (wss_pkg::LEN_W'(k + 1) == len_eff),
                .prev_match   (prev),
                .match        (match_vec[k]),
                .hit          (hit_vec[k])
            );
        end
    endgenerate

    assign any_hit    = |hit_vec;
    assign start_full = SUB_W'(count_inc) - SUB_W'(len_eff) + SUB_W'(1);

    always_comb
    begin
        count_next    = count_reg;
        reported_next = reported_reg;
        push          = 1'b0;
        new_result    = '0;
        if (step)
        begin
            count_next = count_inc;
            if (any_hit)
            begin
                push           = 1'b1;
                new_result.found = 1'b1;
                new_result.pos   = start_full[wss_pkg::POS_W-1:0];
                reported_next  = 1'b1;
            end
            else if (end_of_sentence)
            begin
                push = 1'b1;
            end
        end
        if (in_accept && end_of_sentence)
        begin
            count_next    = '0;
            reported_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            reported_reg <= reported_next;
        end
    end

    // Result buffer: output register plus skid register.
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    assign text_ready = !skid_valid_reg;
    assign pop        = out_valid_reg && result_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = new_result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_data_next  = new_result;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = new_result;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_valid   = out_valid_reg;
    assign found          = out_data_reg.found;
    assign start_position = out_data_reg.pos;
    assign last           = 1'b1;

    `WSS_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid word held without an output word")
    `WSS_ASSERT_NOW(a_no_result_after_report, clk, rst_n, in_accept && reported_reg, !push, "result produced after the match was reported")
    `WSS_ASSERT_NEXT(a_sentence_clear, clk, rst_n, in_accept && end_of_sentence, (count_reg == '0) && !reported_reg && (match_vec == '0), "state not cleared after the final word")
    `WSS_ASSERT_NEXT(a_skid_refill, clk, rst_n, pop && skid_valid_reg, out_valid_reg && !skid_valid_reg, "skid word lost on output pop")

endmodule
